### sv/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types, codes and sizes for the positional list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 7;

    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
    localparam logic [OP_W-1:0] OP_AT     = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_ISSUE,
        S_LOOP,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic init_idx;
        logic mem_rd;
        logic rd_at_pos;
        logic mem_wr;
        logic put;
        logic step_idx;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ok_read;
        logic ok_insert;
        logic ok_delete;
        logic more;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### sv/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl
// Sequencer for one request: decide, shift entries one at a time, respond.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_stall,
    input  wire pls_pkg::t_stat i_stat,
    output pls_pkg::t_cmd      o_cmd
);

    pls_pkg::t_state r_state;
    pls_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pls_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pls_pkg::S_IDLE: begin
                if (i_req_valid) n_state = pls_pkg::S_DECIDE;
            end
            pls_pkg::S_DECIDE: begin
                if (i_stat.ok_read) n_state = pls_pkg::S_RD_ISSUE;
                else if (i_stat.ok_insert || i_stat.ok_delete) n_state = pls_pkg::S_LOOP;
                else n_state = pls_pkg::S_FINISH;
            end
            pls_pkg::S_RD_ISSUE: n_state = pls_pkg::S_FINISH;
            pls_pkg::S_LOOP: begin
                if (i_stat.more) n_state = pls_pkg::S_SH_RD;
                else if (i_stat.ok_insert) n_state = pls_pkg::S_PUT;
                else n_state = pls_pkg::S_FINISH;
            end
            pls_pkg::S_SH_RD: n_state = pls_pkg::S_SH_WR;
            pls_pkg::S_SH_WR: n_state = pls_pkg::S_LOOP;
            pls_pkg::S_PUT:   n_state = pls_pkg::S_FINISH;
            pls_pkg::S_FINISH: begin
                if (i_stat.out_free) n_state = pls_pkg::S_IDLE;
            end
            default: n_state = pls_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_stall = 1'b1;
        case (r_state)
            pls_pkg::S_IDLE: begin
                o_req_stall  = 1'b0;
                o_cmd.load_req = i_req_valid;
            end
            pls_pkg::S_DECIDE: o_cmd.init_idx = 1'b1;
            pls_pkg::S_RD_ISSUE: begin
                o_cmd.mem_rd    = 1'b1;
                o_cmd.rd_at_pos = 1'b1;
            end
            pls_pkg::S_SH_RD: o_cmd.mem_rd = 1'b1;
            pls_pkg::S_SH_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.step_idx = 1'b1;
            end
            pls_pkg::S_PUT: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.put    = 1'b1;
            end
            pls_pkg::S_FINISH: o_cmd.finish = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### sv/pls_dp.sv
// ----------------------------------------------------------------------------
// pls_dp
// Entry memory, count, request and shift registers, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pls_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pls_pkg::t_req i_req,
    input  wire pls_pkg::t_cmd i_cmd,
    output pls_pkg::t_stat     o_stat,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_stall,
    output pls_pkg::t_rsp      o_rsp
);

    logic signed [pls_pkg::VAL_W-1:0] r_mem [pls_pkg::CAPACITY];
    logic signed [pls_pkg::VAL_W-1:0] r_rdata;

    pls_pkg::t_req                r_req;
    logic [pls_pkg::CNT_W-1:0]    r_count;
    logic [pls_pkg::CNT_W-1:0]    r_idx;
    logic                         r_out_valid;
    pls_pkg::t_rsp                r_out;

    logic                         is_insert;
    logic                         is_full;
    logic                         ok_read;
    logic                         ok_insert;
    logic                         ok_delete;
    logic [pls_pkg::ST_W-1:0]     st;
    logic [pls_pkg::CNT_W-1:0]    slot;
    logic                         more;
    logic [pls_pkg::CNT_W-1:0]    rd_idx;
    logic [pls_pkg::ADDR_W-1:0]   rd_addr;
    logic [pls_pkg::ADDR_W-1:0]   wr_addr;
    logic signed [pls_pkg::VAL_W-1:0] wr_data;
    logic [pls_pkg::CNT_W-1:0]    n_count;

    // Classify the held request against the current count.
    always_comb begin
        is_full   = (r_count >= pls_pkg::CNT_W'(pls_pkg::CAPACITY));
        is_insert = 1'b0;
        ok_read   = 1'b0;
        ok_insert = 1'b0;
        ok_delete = 1'b0;
        st        = pls_pkg::ST_RANGE;
        slot      = r_count;
        case (r_req.op)
            pls_pkg::OP_READ: begin
                ok_read = (r_req.position < r_count);
                st      = ok_read ? pls_pkg::ST_DONE : pls_pkg::ST_RANGE;
            end
            pls_pkg::OP_HEAD, pls_pkg::OP_TAIL: begin
                is_insert = 1'b1;
                ok_insert = !is_full;
                st        = is_full ? pls_pkg::ST_FULL : pls_pkg::ST_DONE;
                slot      = (r_req.op == pls_pkg::OP_HEAD) ? '0 : r_count;
            end
            pls_pkg::OP_AT: begin
                is_insert = 1'b1;
                slot      = r_req.position;
                if (r_req.position > r_count) begin
                    st = pls_pkg::ST_RANGE;
                end else if (is_full) begin
                    st = pls_pkg::ST_FULL;
                end else begin
                    ok_insert = 1'b1;
                    st        = pls_pkg::ST_DONE;
                end
            end
            pls_pkg::OP_DELETE: begin
                ok_delete = (r_req.position < r_count);
                st        = ok_delete ? pls_pkg::ST_DONE : pls_pkg::ST_RANGE;
            end
            default: st = pls_pkg::ST_RANGE;
        endcase
    end

    // Insert walks down from the tail to the slot; delete walks up to the tail.
    assign more    = is_insert ? (r_idx > slot) : ((r_idx + 1'b1) < r_count);
    assign rd_idx  = i_cmd.rd_at_pos ? r_req.position
                   : (is_insert ? (r_idx - 1'b1) : (r_idx + 1'b1));
    assign rd_addr = rd_idx[pls_pkg::ADDR_W-1:0];
    assign wr_addr = i_cmd.put ? slot[pls_pkg::ADDR_W-1:0] : r_idx[pls_pkg::ADDR_W-1:0];
    assign wr_data = i_cmd.put ? r_req.value : r_rdata;

    assign n_count = ok_insert ? (r_count + 1'b1)
                   : (ok_delete ? (r_count - 1'b1) : r_count);

    assign o_stat.ok_read   = ok_read;
    assign o_stat.ok_insert = ok_insert;
    assign o_stat.ok_delete = ok_delete;
    assign o_stat.more      = more;
    assign o_stat.out_free  = !r_out_valid || !i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) r_mem[wr_addr] <= wr_data;
        if (i_cmd.mem_rd) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_req <= i_req;
        if (i_cmd.init_idx) begin
            r_idx <= is_insert ? r_count : r_req.position;
        end else if (i_cmd.step_idx) begin
            r_idx <= is_insert ? (r_idx - 1'b1) : (r_idx + 1'b1);
        end
        if (i_cmd.finish) begin
            r_out.read_value <= ok_read ? r_rdata : '0;
            r_out.status     <= st;
            r_out.count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

### sv/positional_list_store.sv
// An insert or delete shifts entries one at a time between the slot and the tail;
// a read or a refused request moves no entry.
// Throughput: one request at a time, the next taken once the result is loaded; the
// single-port entry memory moves one entry per read/write pair.
// Reset (synchronous, active low) empties the list and drops any held result;
// the entry memory itself is not cleared, as entries beyond the count are never read.
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed values with read, insert and delete by position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // request channel
    input  wire logic          i_req_valid,
    output logic               o_req_stall,
    input  wire pls_pkg::t_req i_req,
    // result channel
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_stall,
    output pls_pkg::t_rsp      o_rsp
);

    // Commands flow down from the sequencer; status flows back up.
    pls_pkg::t_cmd  cmd;
    pls_pkg::t_stat stat;

    // Sequencer: take a request only when idle, hold it until the result
    // register is free to accept the outcome.
    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: entry memory, count, shift index and the result register that
    // parts the result side from the request side.
    pls_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

### sv/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks on the result channel of the positional list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pls_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_rsp_valid,
    input wire logic          i_rsp_stall,
    input wire pls_pkg::t_rsp o_rsp
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled result changed");

    // Reset drops any pending result.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid after reset");

    // Count never exceeds the capacity.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.count <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
        else $error("count above capacity");

    // A full refusal only happens with a full list.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == pls_pkg::ST_FULL
        |-> o_rsp.count == pls_pkg::CNT_W'(pls_pkg::CAPACITY))
        else $error("full status with room left");

    // Anything but a completed request returns zero data.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != pls_pkg::ST_DONE |-> o_rsp.read_value == '0)
        else $error("refused request returned data");

endmodule

bind positional_list_store pls_checker u_pls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

`default_nettype wire

### sim/positional_list_store_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_test
// Self-checking bench for the positional list store: drives directed and
// phased random requests with random idling on both channels, predicts each
// result from a shadow copy of the list and compares every field in order.
// ----------------------------------------------------------------------------

module positional_list_store_test;

    import pls_pkg::*;

    localparam int RANDOM_ITEMS   = 800;
    localparam int WATCHDOG_LIMIT = 4000;
    // worst insert or delete: every entry moved, plus the fixed overhead
    localparam int DRAIN_CYCLES   = 3 * CAPACITY + 8;

    typedef enum {PH_GROW, PH_CHURN, PH_SHRINK} t_phase;

    // ------------------------------------------------------------------------
    // Shadow list and pending outcomes. Each accepted request is applied to
    // the shadow at once; the outcome it gives waits in order for its result.
    // ------------------------------------------------------------------------
    class list_checker;
        logic signed [VAL_W-1:0] shadow[$];
        t_rsp                    outcomes[$];
        int                      failures;
        int                      results_seen;

        function int stored();
            return shadow.size();
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        function void note_request(t_req r);
            t_rsp o;
            int   pos;
            o      = '0;
            o.status = ST_DONE;
            pos    = int'(r.position);
            case (r.op)
                OP_READ: begin
                    if (pos < shadow.size()) o.read_value = shadow[pos];
                    else o.status = ST_RANGE;
                end
                OP_HEAD, OP_TAIL: begin
                    if (shadow.size() >= CAPACITY) o.status = ST_FULL;
                    else if (r.op == OP_HEAD) shadow.push_front(r.value);
                    else shadow.push_back(r.value);
                end
                OP_AT: begin
                    // range is judged before fullness
                    if (pos > shadow.size()) o.status = ST_RANGE;
                    else if (shadow.size() >= CAPACITY) o.status = ST_FULL;
                    else shadow.insert(pos, r.value);
                end
                OP_DELETE: begin
                    if (pos < shadow.size()) shadow.delete(pos);
                    else o.status = ST_RANGE;
                end
                default: o.status = ST_RANGE;
            endcase
            o.count = CNT_W'(shadow.size());
            outcomes.push_back(o);
        endfunction

        task report_mismatch(string msg);
            failures++;
            // cap the log; keep counting regardless
            if (failures <= 100) $display("mismatch at result %0d: %s", results_seen, msg);
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            if (outcomes.size() == 0) begin
                report_mismatch("result arrived with no request pending");
            end else begin
                want = outcomes.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %0d, expected %0d",
                                              got.read_value, want.read_value));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              got.count, want.count));
            end
            results_seen++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic req_valid = 1'b0;
    t_req req       = '0;
    logic rsp_stall = 1'b0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;

    list_checker board;
    bit          no_idle = 1'b0;
    int          stall_run = 0;
    int          quiet = 0;

    positional_list_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then a long pause.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req make_request(logic [OP_W-1:0] op, int pos,
                                          logic signed [VAL_W-1:0] val);
        t_req r;
        r.op       = op;
        r.position = POS_W'(pos);
        r.value    = val;
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed requests against the current list length; the phase
    // weights push the list towards full or empty, with some noise on top.
    function automatic t_req random_request(t_phase ph);
        t_req r;
        int   n;
        int   roll;
        n    = board.stored();
        roll = $urandom_range(0, 99);
        case (ph)
            PH_GROW:   r.op = roll < 10 ? OP_READ : roll < 30 ? OP_HEAD :
                              roll < 50 ? OP_TAIL : roll < 88 ? OP_AT : OP_DELETE;
            PH_SHRINK: r.op = roll < 15 ? OP_READ : roll < 20 ? OP_HEAD :
                              roll < 25 ? OP_TAIL : roll < 32 ? OP_AT : OP_DELETE;
            default:   r.op = roll < 25 ? OP_READ : roll < 40 ? OP_HEAD :
                              roll < 55 ? OP_TAIL : roll < 75 ? OP_AT : OP_DELETE;
        endcase
        // unassigned operation codes: the block must refuse them
        if ($urandom_range(0, 99) < 3) r.op = OP_DELETE + OP_W'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0) r.position = POS_W'($urandom_range(0, 127));
        else if (r.op == OP_AT) r.position = POS_W'($urandom_range(0, n));
        else if (n > 0) r.position = POS_W'($urandom_range(0, n - 1));
        else r.position = '0;
        r.value = pick_value();
        return r;
    endfunction

    // Present one request and hold it until the block takes it. Valid stays
    // high into the next request when no gap is drawn.
    task automatic issue_request(input t_req r);
        int gap;
        gap = no_idle ? 0 : idle_length();
        @(negedge i_clk);
        if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req       = r;
        req_valid = 1'b1;
        do @(posedge i_clk); while (o_req_stall);
        board.note_request(r);
    endtask

    task automatic directed_requests();
        int k;
        // empty list: everything positional is out of range
        issue_request(make_request(OP_READ, 0, 0));
        issue_request(make_request(OP_DELETE, 0, 0));
        issue_request(make_request(OP_AT, 1, 7));
        // insert at position equal to count appends
        issue_request(make_request(OP_AT, 0, 32'sh7FFF_FFFF));
        issue_request(make_request(OP_HEAD, 127, 32'sh8000_0000));
        issue_request(make_request(OP_TAIL, 0, -1));
        issue_request(make_request(OP_TAIL, 64, 0));
        issue_request(make_request(OP_AT, 2, 32'sh5A5A_5A5A));
        issue_request(make_request(OP_AT, 5, 32'shA5A5_A5A5));
        // insert beyond count
        issue_request(make_request(OP_AT, 7, 1));
        issue_request(make_request(OP_AT, 127, 1));
        issue_request(make_request(OP_READ, 0, 0));
        issue_request(make_request(OP_READ, 5, 0));
        issue_request(make_request(OP_READ, 6, 0));
        issue_request(make_request(OP_READ, 127, -1));
        for (k = 1; k <= 3; k++)
            issue_request(make_request(OP_DELETE + OP_W'(k), 127, -1));
        // delete head, tail and middle, then beyond the end
        issue_request(make_request(OP_DELETE, 0, 0));
        issue_request(make_request(OP_DELETE, 4, 0));
        issue_request(make_request(OP_DELETE, 1, 0));
        issue_request(make_request(OP_DELETE, 64, 0));
        issue_request(make_request(OP_READ, 2, 0));
    endtask

    // Result side stall: alternate ready and stalled runs; calm phases hold
    // stall low throughout.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            if (no_idle) begin
                rsp_stall = 1'b0;
                stall_run = $urandom_range(1, 20);
            end else if ($urandom_range(0, 99) < 55) begin
                rsp_stall = 1'b0;
                stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
                                                        : $urandom_range(1, 6);
            end else begin
                rsp_stall = 1'b1;
                stall_run = 1 + idle_length();
            end
        end
        stall_run = stall_run - 1;
    end

    // Check results and watch for a stuck handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet = 0;
        end else begin
            if (o_rsp_valid && !rsp_stall) board.check_result(o_rsp);
            if ((req_valid && !o_req_stall) || (o_rsp_valid && !rsp_stall)) begin
                quiet = 0;
            end else if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         quiet, board.pending());
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet++;
            end
        end
    end

    initial begin
        t_req   r;
        t_phase phase;
        t_phase heading;
        int     counted;
        int     span;
        board = new();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_requests();

        // Grow towards full, churn, shrink towards empty, churn, and again.
        counted = 0;
        phase   = PH_GROW;
        heading = PH_GROW;
        while (counted < RANDOM_ITEMS) begin
            span    = $urandom_range(60, 160);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (span) begin
                r = random_request(phase);
                issue_request(r);
                if (r.op <= OP_DELETE) counted++;
            end
            if (phase != PH_CHURN) begin
                phase = PH_CHURN;
            end else begin
                heading = (heading == PH_GROW) ? PH_SHRINK : PH_GROW;
                phase   = heading;
            end
        end
        no_idle = 1'b0;

        @(negedge i_clk);
        req_valid = 1'b0;
        // drain, then give any stray result time to show up
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.failures == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
